/* rtl/core/sdd_pkg.sv */
// Package for the stepper door drive: register codes, reset values,
// half-step coil table and the record types shared by the core files.
// No dependencies.
`default_nettype none

package sdd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FULL_OPEN_STEPS = 3'd0,
      CSR_STEP_PERIOD     = 3'd1,
      CSR_CONTROL_PERIOD  = 3'd2,
      CSR_MINUTE_COUNT    = 3'd3,
      CSR_HOUR_LIMIT      = 3'd4
   } csr_index_type;

   localparam logic [15:0] FULL_OPEN_STEPS_RST = 16'd1000;
   localparam logic [3:0]  STEP_PERIOD_RST     = 4'd3;
   localparam logic [6:0]  CONTROL_PERIOD_RST  = 7'd100;
   localparam logic [15:0] MINUTE_COUNT_RST    = 16'd36000;
   localparam logic [7:0]  HOUR_LIMIT_RST      = 8'd24;

   typedef struct packed {
      logic [15:0] full_open_steps;
      logic [3:0]  step_period;
      logic [6:0]  control_period;
      logic [15:0] minute_count;
      logic [7:0]  hour_limit;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  coils;
      logic [15:0] position;
      logic        open_request;
      logic        moving_open;
      logic        forced_close_pending;
   } result_type;

   function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
      logic [3:0] c;
      case (phase)
         3'd0: c = 4'h1;
         3'd1: c = 4'h9;
         3'd2: c = 4'h8;
         3'd3: c = 4'hC;
         3'd4: c = 4'h4;
         3'd5: c = 4'h6;
         3'd6: c = 4'h2;
         3'd7: c = 4'h3;
         default: c = 4'h0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/sdd_engine.sv */
// Door drive state and per-tick update: prescalers, motor step, forced close timer.
// Depends on sdd_pkg.
`default_nettype none

module sdd_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               tick_en,
   input  wire logic               open_write,
   input  wire logic               open_value,
   input  wire logic               ice_out,
   input  wire sdd_pkg::cfg_type    cfg,
   output sdd_pkg::result_type      result
);
   import sdd_pkg::*;

   logic [6:0]  control_timer_ff, control_timer_in;
   logic [3:0]  step_prescale_ff, step_prescale_in;
   logic        direction_open_ff, direction_open_in;
   logic [15:0] door_position_ff, door_position_in;
   logic        open_flag_ff, open_flag_in;
   logic [3:0]  coil_drive_ff, coil_drive_in;
   logic [15:0] minute_counter_ff, minute_counter_in;
   logic [7:0]  hour_counter_ff, hour_counter_in;
   logic        close_pending_ff, close_pending_in;

   logic [6:0]  ct_inc;
   logic [3:0]  sp_inc;
   logic        do_step, slow_tick;
   logic        open_req;
   logic [15:0] pos_base, pos_step;
   logic [15:0] mc_base, mc_inc;
   logic [7:0]  hc_base, hc_inc;

   always_comb begin
      open_req = open_write ? open_value : open_flag_ff;

      ct_inc = (control_timer_ff < cfg.control_period) ? control_timer_ff + 7'd1
                                                       : control_timer_ff;
      sp_inc = step_prescale_ff + 4'd1;
      do_step = (sp_inc >= cfg.step_period);
      slow_tick = (ct_inc >= cfg.control_period);

      step_prescale_in  = do_step ? 4'd0 : sp_inc;
      control_timer_in  = slow_tick ? 7'd0 : ct_inc;
      open_flag_in      = open_req;
      direction_open_in = direction_open_ff;
      pos_step          = door_position_ff;
      coil_drive_in     = coil_drive_ff;
      pos_base          = door_position_ff;

      // motor half-step
      if (do_step) begin
         if (open_req) begin
            direction_open_in = 1'b1;
            if (door_position_ff < cfg.full_open_steps) begin
               pos_step = door_position_ff + 16'd1;
            end else begin
               pos_step = cfg.full_open_steps;
               if (!ice_out) begin
                  open_flag_in = 1'b0;
               end
            end
         end else begin
            pos_base = direction_open_ff ? cfg.full_open_steps : door_position_ff;
            direction_open_in = 1'b0;
            pos_step = (pos_base != 16'd0) ? pos_base - 16'd1 : pos_base;
         end
         if (pos_step == 16'd0 || pos_step == cfg.full_open_steps) begin
            coil_drive_in = 4'h0;
         end else begin
            coil_drive_in = half_step_coils(pos_step[2:0]);
         end
      end

      // forced close timer
      door_position_in  = pos_step;
      minute_counter_in = minute_counter_ff;
      hour_counter_in   = hour_counter_ff;
      close_pending_in  = close_pending_ff;
      mc_base = ice_out ? 16'd0 : minute_counter_ff;
      hc_base = ice_out ? 8'd0 : hour_counter_ff;
      mc_inc  = mc_base + 16'd1;
      hc_inc  = hc_base;
      if (slow_tick) begin
         minute_counter_in = mc_inc;
         if (mc_inc >= cfg.minute_count) begin
            minute_counter_in = 16'd0;
            hc_inc = hc_base + 8'd1;
         end
         hour_counter_in = hc_inc;
         if (hc_inc >= cfg.hour_limit) begin
            close_pending_in = 1'b1;
            hour_counter_in  = 8'd0;
         end
         if (close_pending_ff) begin
            close_pending_in  = 1'b0;
            minute_counter_in = 16'd0;
            hour_counter_in   = 8'd0;
            door_position_in  = cfg.full_open_steps;
         end
      end

      result.coils                = coil_drive_in;
      result.position             = door_position_in;
      result.open_request         = open_flag_in;
      result.moving_open          = direction_open_in;
      result.forced_close_pending = close_pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_timer_ff  <= '0;
         step_prescale_ff  <= '0;
         direction_open_ff <= 1'b0;
         door_position_ff  <= '0;
         open_flag_ff      <= 1'b0;
         coil_drive_ff     <= '0;
         minute_counter_ff <= '0;
         hour_counter_ff   <= '0;
         close_pending_ff  <= 1'b0;
      end else if (tick_en) begin
         control_timer_ff  <= control_timer_in;
         step_prescale_ff  <= step_prescale_in;
         direction_open_ff <= direction_open_in;
         door_position_ff  <= door_position_in;
         open_flag_ff      <= open_flag_in;
         coil_drive_ff     <= coil_drive_in;
         minute_counter_ff <= minute_counter_in;
         hour_counter_ff   <= hour_counter_in;
         close_pending_ff  <= close_pending_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/stepper_door_drive_with_forced_close.sv */
// Stepper door drive top level: config registers, input register, result register.
// The result is registered: an accepted item passes the input register, then the result
// register; one item per cycle sustained while rsp_ready stays high, set by the state
// update in sdd_engine. A stalled result holds at most one more item in the input register.
// Synchronous active-high reset clears the valid flags and engine state (engine coils off), config to defaults.
// Depends on sdd_pkg and sdd_engine.
`default_nettype none

module stepper_door_drive_with_forced_close (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_open_write,
   input  wire logic                            req_open_value,
   input  wire logic                            req_ice_out,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [3:0]                      rsp_coils,
   output      logic [15:0]                     rsp_position,
   output      logic                            rsp_open_request,
   output      logic                            rsp_moving_open,
   output      logic                            rsp_forced_close_pending,
   input  wire logic                            csr_write_enable,
   input  wire logic [sdd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sdd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sdd_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_open_write_ff, in_open_value_ff, in_ice_out_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type next_result;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_open_steps <= FULL_OPEN_STEPS_RST;
         cfg_ff.step_period     <= STEP_PERIOD_RST;
         cfg_ff.control_period  <= CONTROL_PERIOD_RST;
         cfg_ff.minute_count    <= MINUTE_COUNT_RST;
         cfg_ff.hour_limit      <= HOUR_LIMIT_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FULL_OPEN_STEPS: cfg_ff.full_open_steps <= csr_data;
            CSR_STEP_PERIOD:     cfg_ff.step_period     <= csr_data[3:0];
            CSR_CONTROL_PERIOD:  cfg_ff.control_period  <= csr_data[6:0];
            CSR_MINUTE_COUNT:    cfg_ff.minute_count    <= csr_data;
            CSR_HOUR_LIMIT:      cfg_ff.hour_limit      <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_open_write_ff <= req_open_write;
         in_open_value_ff <= req_open_value;
         in_ice_out_ff    <= req_ice_out;
      end
      if (advance) begin
         out_ff <= next_result;
      end
   end

   sdd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (advance),
      .open_write (in_open_write_ff),
      .open_value (in_open_value_ff),
      .ice_out    (in_ice_out_ff),
      .cfg        (cfg_ff),
      .result     (next_result)
   );

   assign rsp_valid                = out_valid_ff;
   assign rsp_coils                = out_ff.coils;
   assign rsp_position             = out_ff.position;
   assign rsp_open_request         = out_ff.open_request;
   assign rsp_moving_open          = out_ff.moving_open;
   assign rsp_forced_close_pending = out_ff.forced_close_pending;

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for the stepper door drive: a per-item door/coil predictor
// in a small scoreboard class, random handshake stalls on both channels.
// Depends on sdd_pkg and the stepper_door_drive_with_forced_close top level.
`timescale 1ns / 100ps

class door_scoreboard;
   logic [15:0] full_open;
   logic [3:0]  step_len;
   logic [6:0]  ctl_len;
   logic [15:0] minute_len;
   logic [7:0]  hour_len;

   logic [6:0]  ctl_tmr;
   logic [3:0]  prescale;
   logic        dir_open;
   logic [15:0] pos;
   logic        open_req;
   logic [3:0]  coil;
   logic [15:0] min_cnt;
   logic [7:0]  hr_cnt;
   logic        close_pend;

   sdd_pkg::result_type expected_q[$];
   int errors;

   function new();
      full_open  = sdd_pkg::FULL_OPEN_STEPS_RST;
      step_len   = sdd_pkg::STEP_PERIOD_RST;
      ctl_len    = sdd_pkg::CONTROL_PERIOD_RST;
      minute_len = sdd_pkg::MINUTE_COUNT_RST;
      hour_len   = sdd_pkg::HOUR_LIMIT_RST;
      ctl_tmr    = '0;
      prescale   = '0;
      dir_open   = 1'b0;
      pos        = '0;
      open_req   = 1'b0;
      coil       = '0;
      min_cnt    = '0;
      hr_cnt     = '0;
      close_pend = 1'b0;
      errors     = 0;
   endfunction

   function void set_reg(sdd_pkg::csr_index_type idx, logic [15:0] v);
      case (idx)
         sdd_pkg::CSR_FULL_OPEN_STEPS: full_open  = v;
         sdd_pkg::CSR_STEP_PERIOD:     step_len   = v[3:0];
         sdd_pkg::CSR_CONTROL_PERIOD:  ctl_len    = v[6:0];
         sdd_pkg::CSR_MINUTE_COUNT:    minute_len = v;
         sdd_pkg::CSR_HOUR_LIMIT:      hour_len   = v[7:0];
         default: ;
      endcase
   endfunction

   function void advance_motor(bit ice);
      if (open_req) begin
         dir_open = 1'b1;
         if (pos < full_open) begin
            pos = pos + 16'd1;
         end else begin
            pos = full_open;
            if (!ice) open_req = 1'b0;
         end
      end else begin
         if (dir_open) begin
            pos = full_open;
            dir_open = 1'b0;
         end
         if (pos != 16'd0) pos = pos - 16'd1;
      end
      if (pos == 16'd0 || pos == full_open) begin
         coil = 4'h0;
      end else begin
         case (pos[2:0])
            3'd0: coil = 4'h1;
            3'd1: coil = 4'h9;
            3'd2: coil = 4'h8;
            3'd3: coil = 4'hC;
            3'd4: coil = 4'h4;
            3'd5: coil = 4'h6;
            3'd6: coil = 4'h2;
            default: coil = 4'h3;
         endcase
      end
   endfunction

   function void slow_control(bit ice);
      logic was_pend;
      was_pend = close_pend;
      if (ice) begin
         min_cnt = '0;
         hr_cnt = '0;
      end
      min_cnt = min_cnt + 16'd1;
      if (min_cnt >= minute_len) begin
         min_cnt = '0;
         hr_cnt = hr_cnt + 8'd1;
      end
      if (hr_cnt >= hour_len) begin
         close_pend = 1'b1;
         hr_cnt = '0;
      end
      if (was_pend) begin
         close_pend = 1'b0;
         min_cnt = '0;
         hr_cnt = '0;
         pos = full_open;
      end
   endfunction

   // one accepted tick item
   function void note_tick(bit wr, bit val, bit ice);
      sdd_pkg::result_type r;
      if (wr) open_req = val;
      if (ctl_tmr < ctl_len) ctl_tmr = ctl_tmr + 7'd1;
      prescale = prescale + 4'd1;
      if (prescale >= step_len) begin
         prescale = '0;
         advance_motor(ice);
      end
      if (ctl_tmr >= ctl_len) begin
         ctl_tmr = '0;
         slow_control(ice);
      end
      r.coils                = coil;
      r.position             = pos;
      r.open_request         = open_req;
      r.moving_open          = dir_open;
      r.forced_close_pending = close_pend;
      expected_q.push_back(r);
   endfunction

   function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_result(sdd_pkg::result_type got);
      sdd_pkg::result_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected item, actual %h", $time, got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("coils", 32'(want.coils), 32'(got.coils));
      compare_field("position", 32'(want.position), 32'(got.position));
      compare_field("open_request", 32'(want.open_request), 32'(got.open_request));
      compare_field("moving_open", 32'(want.moving_open), 32'(got.moving_open));
      compare_field("forced_close_pending", 32'(want.forced_close_pending),
                    32'(got.forced_close_pending));
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_open_write = 1'b0;
   logic req_open_value = 1'b0;
   logic req_ice_out = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0]  rsp_coils;
   logic [15:0] rsp_position;
   logic rsp_open_request;
   logic rsp_moving_open;
   logic rsp_forced_close_pending;
   logic csr_write_enable = 1'b0;
   logic [sdd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sdd_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   bit ice_level = 1'b0;

   door_scoreboard sb = new();

   stepper_door_drive_with_forced_close dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      sdd_pkg::result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.coils                = rsp_coils;
         got.position             = rsp_position;
         got.open_request         = rsp_open_request;
         got.moving_open          = rsp_moving_open;
         got.forced_close_pending = rsp_forced_close_pending;
         sb.check_result(got);
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_tick(input bit ow, input bit ov, input bit ice);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_open_write <= ow;
      req_open_value <= ov;
      req_ice_out    <= ice;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(ow, ov, ice);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input sdd_pkg::csr_index_type idx, input logic [15:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic configure(input logic [15:0] f, input logic [3:0] s, input logic [6:0] c,
                            input logic [15:0] m, input logic [7:0] h);
      drain();
      write_reg(sdd_pkg::CSR_FULL_OPEN_STEPS, f);
      write_reg(sdd_pkg::CSR_STEP_PERIOD, {12'd0, s});
      write_reg(sdd_pkg::CSR_CONTROL_PERIOD, {9'd0, c});
      write_reg(sdd_pkg::CSR_MINUTE_COUNT, m);
      write_reg(sdd_pkg::CSR_HOUR_LIMIT, {8'd0, h});
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_tick();
      if ($urandom_range(0, 9) == 0) begin
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else begin
         if ($urandom_range(0, 19) == 0) ice_level = ~ice_level;
         send_tick($urandom_range(0, 11) == 0, $urandom_range(0, 9) < 7, ice_level);
      end
   endtask

   initial begin
      logic [15:0] f;
      logic [3:0]  s;
      logic [6:0]  c;
      logic [15:0] m;
      logic [7:0]  h;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      repeat (3) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1, 1'b0);

      // short door: open to the stop, hold with ice, close, reverse mid-sweep
      configure(16'd3, 4'd1, 7'd2, 16'd1, 8'd1);
      send_tick(1'b1, 1'b1, 1'b0);
      repeat (4) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1, 1'b1);
      repeat (4) send_tick(1'b0, 1'b1, 1'b1);
      repeat (3) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b1);
      repeat (3) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      repeat (2) send_tick(1'b0, 1'b1, 1'b1);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 57 : 0;
         recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 31 : 0;
         for (int st = 0; st < 3; st++) begin
            if (ph == 0 && st == 0) begin
               configure(16'hFFFF, 4'd15, 7'd127, 16'hFFFF, 8'd255);
            end else if (ph == 1 && st == 0) begin
               configure(16'd1, 4'd1, 7'd1, 16'd1, 8'd1);
            end else begin
               f = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                   : $urandom_range(1, 12));
               s = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 15)
                                                  : $urandom_range(1, 3));
               c = 7'(($urandom_range(0, 5) == 0) ? $urandom_range(1, 127)
                                                  : $urandom_range(1, 6));
               m = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                   : $urandom_range(1, 3));
               h = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 3));
               configure(f, s, c, m, h);
            end
            for (int n = 0; n < 150; n++) begin
               if (st == 1 && n == 75) drain();
               random_tick();
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected items never arrived", $time, sb.pending());
         $display("simulation failed");
      end
      $finish;
   end
endmodule

/* stepper_door_drive_with_forced_close.f */
rtl/core/sdd_pkg.sv
rtl/core/sdd_engine.sv
rtl/core/stepper_door_drive_with_forced_close.sv
bench/tb.sv
